### design/ipv4bl_pkg.sv
// ----------------------------------------------------------------------------
// ipv4bl_pkg: shared types and constants of the IPv4 destination blacklist
// Table size, lookup key and entry layouts, verdict codes, and the
// request and response bundles between the frame parser and the table.
// ----------------------------------------------------------------------------
package ipv4bl_pkg;

  localparam int TableEntries = 16;
  localparam int TabAw = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  // Ethernet / IPv4 framing constants
  localparam logic [6:0]  EthLen    = 7'd14;
  localparam logic [15:0] Ipv4Type  = 16'h0800;
  localparam logic [6:0]  IpMinEnd  = 7'd34;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  ProtoUdp  = 8'd17;
  localparam logic [7:0]  TcpLen    = 8'd20;
  localparam logic [7:0]  UdpLen    = 8'd8;
  localparam logic [3:0]  IhlMin    = 4'd5;
  localparam logic [6:0]  OffsetMax = 7'd127;

  typedef enum logic [2:0] {
    RsnHit    = 3'd0,
    RsnMiss   = 3'd1,
    RsnShort  = 3'd2,
    RsnNotIp  = 3'd3,
    RsnBadIhl = 3'd4
  } reason_e;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  proto;
  } key_t;

  typedef struct packed {
    key_t key;
    logic action;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [TabAw-1:0] addr;
    logic             valid;
    entry_t           entry;
  } tbl_wr_t;

  typedef struct packed {
    logic start;
    key_t key;
  } scan_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_rsp_t;

endpackage

### design/ipv4bl_table.sv
// ----------------------------------------------------------------------------
// ipv4bl_table: blacklist table with a sequential lookup
// Holds the banned keys and walks them one entry per cycle through a single
// key comparator, reporting a hit or miss once the last entry is checked.
// ----------------------------------------------------------------------------
module ipv4bl_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ipv4bl_pkg::tbl_wr_t   wr_i,
  input  ipv4bl_pkg::scan_req_t req_i,
  output ipv4bl_pkg::scan_rsp_t rsp_o
);

  localparam int Aw = ipv4bl_pkg::TabAw;
  localparam logic [Aw-1:0] LastIdx = Aw'(ipv4bl_pkg::TableEntries - 1);

  ipv4bl_pkg::entry_t mem_q [ipv4bl_pkg::TableEntries];
  logic [ipv4bl_pkg::TableEntries-1:0] vld_q, vld_d;

  logic               busy_q, busy_d;
  logic [Aw-1:0]      cnt_q, cnt_d;
  ipv4bl_pkg::key_t   key_q;
  logic               stg_q, stg_d;
  logic               stg_last_q, stg_last_d;
  ipv4bl_pkg::entry_t rd_q;
  logic               rd_vld_q;
  logic               hit_q, hit_d;
  logic               done_q, done_d;
  logic               res_q, res_d;
  logic               match;

  // Entry payload: written and read at one address each, read registered
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.entry;
    end
    rd_q     <= mem_q[cnt_q];
    rd_vld_q <= vld_q[cnt_q];
    if (req_i.start) begin
      key_q <= req_i.key;
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (wr_i.en) begin
      vld_d[wr_i.addr] = wr_i.valid;
    end
  end

  assign match = stg_q & rd_vld_q & ~rd_q.action & (rd_q.key == key_q);

  always_comb begin
    busy_d     = busy_q;
    cnt_d      = cnt_q;
    stg_d      = 1'b0;
    stg_last_d = 1'b0;
    hit_d      = hit_q;
    done_d     = 1'b0;
    res_d      = res_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      hit_d  = 1'b0;
    end else if (busy_q) begin
      // issue one read per cycle; the compare follows in the cycle after
      stg_d      = 1'b1;
      stg_last_d = (cnt_q == LastIdx);
      if (cnt_q == LastIdx) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
    if (stg_q) begin
      hit_d = hit_q | match;
      if (stg_last_q) begin
        done_d = 1'b1;
        res_d  = hit_q | match;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      busy_q     <= 1'b0;
      cnt_q      <= '0;
      stg_q      <= 1'b0;
      stg_last_q <= 1'b0;
      hit_q      <= 1'b0;
      done_q     <= 1'b0;
      res_q      <= 1'b0;
    end else begin
      vld_q      <= vld_d;
      busy_q     <= busy_d;
      cnt_q      <= cnt_d;
      stg_q      <= stg_d;
      stg_last_q <= stg_last_d;
      hit_q      <= hit_d;
      done_q     <= done_d;
      res_q      <= res_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.hit  = res_q;

endmodule

### design/ipv4_dest_blacklist_filter.sv
// ----------------------------------------------------------------------------
// ipv4_dest_blacklist_filter: drop IPv4 frames to blacklisted destinations
// Parses frame bytes for EtherType, IHL, protocol, destination address and
// port, then, if the frame passes its checks, looks the key up in a loadable table.
// ----------------------------------------------------------------------------
//  channel  | dir | tuser    | tlast      | tdata
//  s_axis   | in  | req_type | frame_last | byte, table entry fields
//  m_axis   | out | -        | -          | verdict, reason, drop count
//
//  After a last byte the frame is judged and, when the key is looked up,
//  the table is read one entry per cycle through one
//  comparator. The input is not ready meanwhile.
//  Any transaction is held off while an earlier verdict waits on m_axis.
//  Reset clears all table valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ipv4_dest_blacklist_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] frame_byte, [11:8] entry_index, [12] entry_valid, [44:13] entry_ip,
  // [60:45] entry_port, [68:61] entry_proto, [69] entry_action, [71:70] zero
  input  logic [71:0] s_axis_tdata,
  // [0] req_type
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] verdict_drop, [3:1] verdict_reason, [67:4] drop_count, [71:68] zero
  output logic [71:0] m_axis_tdata
);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StJudge = 3'b010,
    StScan  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [6:0]  off_q, off_d;
  logic [15:0] eth_q, eth_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] addr_q, addr_d;
  logic [15:0] port_q, port_d;
  logic [63:0] drop_cnt_q, drop_cnt_d;

  logic        out_vld_q, out_vld_d;
  logic        out_drop_q, out_drop_d;
  ipv4bl_pkg::reason_e out_rsn_q, out_rsn_d;

  logic        acc, acc_byte;
  logic [7:0]  byte_in;
  logic [6:0]  port_at;
  logic        is_l4, is_tcp;
  logic [7:0]  need_len;
  logic [7:0]  len8;
  logic        emit, emit_hit;
  ipv4bl_pkg::reason_e pre_rsn;
  logic        pre_done;

  ipv4bl_pkg::tbl_wr_t   tbl_wr;
  ipv4bl_pkg::scan_req_t scan_req;
  ipv4bl_pkg::scan_rsp_t scan_rsp;

  assign s_axis_tready = (state_q == StIdle) & (~out_vld_q | m_axis_tready);
  assign acc      = s_axis_tvalid & s_axis_tready;
  assign acc_byte = acc & ~s_axis_tuser;
  assign byte_in  = s_axis_tdata[7:0];

  // Table writes
  assign tbl_wr.en    = acc & s_axis_tuser &
                        (int'(s_axis_tdata[11:8]) < ipv4bl_pkg::TableEntries);
  assign tbl_wr.addr  = ipv4bl_pkg::TabAw'(s_axis_tdata[11:8]);
  assign tbl_wr.valid = s_axis_tdata[12];
  assign tbl_wr.entry = '{key: '{ip: s_axis_tdata[44:13], port: s_axis_tdata[60:45],
                                 proto: s_axis_tdata[68:61]},
                          action: s_axis_tdata[69]};

  // Transport header sits at 14 + 4*IHL; the port is two bytes into it
  assign port_at = 7'd16 + {1'b0, ihl_q, 2'b00};

  assign is_tcp   = (proto_q == ipv4bl_pkg::ProtoTcp);
  assign is_l4    = is_tcp | (proto_q == ipv4bl_pkg::ProtoUdp);
  assign need_len = 8'(ipv4bl_pkg::EthLen) + {2'b00, ihl_q, 2'b00} +
                    (is_tcp ? ipv4bl_pkg::TcpLen : ipv4bl_pkg::UdpLen);
  // offset after the last byte is the frame length; saturation at 127 is
  // far above every threshold below
  assign len8 = {1'b0, off_q};

  always_comb begin
    pre_done = 1'b1;
    pre_rsn  = ipv4bl_pkg::RsnMiss;
    priority if (off_q < ipv4bl_pkg::EthLen) begin
      pre_rsn = ipv4bl_pkg::RsnShort;
    end else if (eth_q != ipv4bl_pkg::Ipv4Type) begin
      pre_rsn = ipv4bl_pkg::RsnNotIp;
    end else if (off_q < ipv4bl_pkg::IpMinEnd) begin
      pre_rsn = ipv4bl_pkg::RsnShort;
    end else if (ihl_q < ipv4bl_pkg::IhlMin) begin
      pre_rsn = ipv4bl_pkg::RsnBadIhl;
    end else if (is_l4 && (len8 < need_len)) begin
      pre_rsn = ipv4bl_pkg::RsnShort;
    end else begin
      pre_done = 1'b0;
    end
  end

  assign scan_req.start     = (state_q == StJudge) & ~pre_done;
  assign scan_req.key.ip    = addr_q;
  assign scan_req.key.port  = is_l4 ? port_q : 16'd0;
  assign scan_req.key.proto = proto_q;

  ipv4bl_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (tbl_wr),
    .req_i  (scan_req),
    .rsp_o  (scan_rsp)
  );

  assign emit     = ((state_q == StJudge) & pre_done) |
                    ((state_q == StScan) & scan_rsp.done);
  assign emit_hit = (state_q == StScan) & scan_rsp.done & scan_rsp.hit;

  always_comb begin
    state_d    = state_q;
    off_d      = off_q;
    eth_d      = eth_q;
    ihl_d      = ihl_q;
    proto_d    = proto_q;
    addr_d     = addr_q;
    port_d     = port_q;
    drop_cnt_d = drop_cnt_q;
    out_vld_d  = out_vld_q & ~m_axis_tready;
    out_drop_d = out_drop_q;
    out_rsn_d  = out_rsn_q;

    unique case (state_q)
      StIdle: begin
        if (acc_byte) begin
          if (off_q == 7'd12) begin
            eth_d = {byte_in, 8'h00};
          end else if (off_q == 7'd13) begin
            eth_d = eth_q | {8'h00, byte_in};
          end else if (off_q == ipv4bl_pkg::EthLen) begin
            ihl_d = byte_in[3:0];
          end else if (off_q == 7'd23) begin
            proto_d = byte_in;
          end else if (off_q >= 7'd30 && off_q <= 7'd33) begin
            addr_d = {addr_q[23:0], byte_in};
          end
          if (off_q > ipv4bl_pkg::EthLen &&
              (off_q == port_at || off_q == port_at + 7'd1)) begin
            port_d = {port_q[7:0], byte_in};
          end
          if (off_q < ipv4bl_pkg::OffsetMax) begin
            off_d = off_q + 7'd1;
          end
          if (s_axis_tlast) begin
            state_d = StJudge;
          end
        end
      end
      StJudge: begin
        if (!pre_done) begin
          state_d = StScan;
        end
      end
      StScan: begin
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (emit) begin
      state_d    = StIdle;
      out_vld_d  = 1'b1;
      out_drop_d = emit_hit;
      out_rsn_d  = (state_q == StJudge) ? pre_rsn :
                   (scan_rsp.hit ? ipv4bl_pkg::RsnHit : ipv4bl_pkg::RsnMiss);
      if (emit_hit) begin
        drop_cnt_d = drop_cnt_q + 64'd1;
      end
      // drop the frame context for the next frame
      off_d   = '0;
      eth_d   = '0;
      ihl_d   = '0;
      proto_d = '0;
      addr_d  = '0;
      port_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      off_q      <= '0;
      eth_q      <= '0;
      ihl_q      <= '0;
      proto_q    <= '0;
      addr_q     <= '0;
      port_q     <= '0;
      drop_cnt_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      off_q      <= off_d;
      eth_q      <= eth_d;
      ihl_q      <= ihl_d;
      proto_q    <= proto_d;
      addr_q     <= addr_d;
      port_q     <= port_d;
      drop_cnt_q <= drop_cnt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_drop_q <= out_drop_d;
    out_rsn_q  <= out_rsn_d;
  end

  // the counter only moves when a verdict is loaded, so it is shown as is
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, drop_cnt_q, out_rsn_q, out_drop_q};

`ifndef SYNTHESIS
  a_busy_not_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !s_axis_tready)
    else $error("input ready while a frame is being judged");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == StJudge || $past(state_q) == StScan))
    else $error("verdict appeared without a judged frame");

  a_drop_is_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_drop_q) |-> (out_rsn_q == ipv4bl_pkg::RsnHit))
    else $error("drop verdict with a reason other than hit");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(drop_cnt_q) |-> (drop_cnt_q == $past(drop_cnt_q) + 64'd1))
    else $error("drop counter moved by other than one");

  a_scan_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_rsp.done |-> (state_q == StScan))
    else $error("table lookup finished outside the scan state");
`endif

endmodule
